>>> src/assert_macros.svh
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SPD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define SPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> src/spd_pkg.sv
`timescale 1ns / 1ps
package spd_pkg;
    localparam int MAX_PAIRS_DEF  = 1024;
    localparam int VALUE_BITS_DEF = 20;
    localparam int DIST_W = 30;
    localparam int SIM_W  = 40;
    localparam int USED_W = 11;

    typedef enum logic [1:0] {
        T_LOAD,
        T_SORT,
        T_MERGE,
        T_PUSH
    } t_top_state;

    typedef enum logic [2:0] {
        L_IDLE,
        L_PRIME,
        L_FIRST,
        L_RUN,
        L_TAIL
    } t_lane_state;

    typedef enum logic [3:0] {
        M_IDLE,
        M_DRD,
        M_DACC,
        M_SRD,
        M_SCMP,
        M_LRD,
        M_LCNT,
        M_RRD,
        M_RCNT,
        M_MUL1,
        M_MUL2,
        M_DONE
    } t_merge_state;

    typedef struct packed {
        logic start;
    } t_lane_ctrl;

    typedef struct packed {
        logic busy;
    } t_lane_stat;

    typedef struct packed {
        logic busy;
        logic done;
    } t_merge_stat;
endpackage

>>> src/spd_if.sv
`timescale 1ns / 1ps
interface spd_in_if #(parameter int VALUE_BITS = spd_pkg::VALUE_BITS_DEF);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] left_value;
    logic [VALUE_BITS-1:0] right_value;
    logic                  last_pair;

    modport source (output valid, output left_value, output right_value,
                    output last_pair, input ready);
    modport sink (input valid, input left_value, input right_value,
                  input last_pair, output ready);
endinterface

interface spd_out_if;
    logic                      valid;
    logic                      ready;
    logic [spd_pkg::DIST_W-1:0] distance_total;
    logic [spd_pkg::SIM_W-1:0]  similarity_total;
    logic [spd_pkg::USED_W-1:0] pairs_used;
    logic                      capacity_exceeded;

    modport source (output valid, output distance_total, output similarity_total,
                    output pairs_used, output capacity_exceeded, input ready);
    modport sink (input valid, input distance_total, input similarity_total,
                  input pairs_used, input capacity_exceeded, output ready);
endinterface

>>> src/sorted_pair_distance_and_match_sum.sv
// one beat per cycle while loading; after the last pair both lists are bubble-sorted in
// memory and then merged; no new pairs are taken until the result is pushed out
// throughput set by the single read and write port of each lane memory during the sort
// both lanes sort in parallel; the merge stage walks both sorted lists twice, for distance then match sum
// reset: control state, pair count and drop flag clear; list memories stay undefined
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sorted_pair_distance_and_match_sum import spd_pkg::*; #(
    parameter int MAX_PAIRS  = MAX_PAIRS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spd_in_if.sink    i_in,
    spd_out_if.source o_out
);
    localparam int AW = $clog2(MAX_PAIRS);
    localparam int CW = $clog2(MAX_PAIRS + 1);

    t_top_state    r_state, n_state;
    logic [CW-1:0] r_cnt, r_n;
    logic          r_drop, r_drop_out;
    logic          r_ovalid;
    logic [DIST_W-1:0] r_odist;
    logic [SIM_W-1:0]  r_osim;
    logic [USED_W-1:0] r_oused;
    logic              r_oexc;

    logic          acc, has_room, wr_en, push;
    logic [CW-1:0] cnt_new;
    t_lane_ctrl    lane_ctrl;
    t_lane_stat    stat_l, stat_r;
    t_merge_stat   mstat;
    logic [AW-1:0] addr_l, addr_r;
    logic [VALUE_BITS-1:0] data_l, data_r;
    logic [DIST_W-1:0] m_dist;
    logic [SIM_W-1:0]  m_sim;

    assign i_in.ready = (r_state == T_LOAD);
    assign acc        = i_in.valid && i_in.ready;
    assign has_room   = (r_cnt < CW'(MAX_PAIRS));
    assign wr_en      = acc && has_room;
    assign cnt_new    = has_room ? CW'(r_cnt + 1'b1) : r_cnt;
    assign push       = (r_state == T_PUSH) && (!r_ovalid || o_out.ready);
    assign lane_ctrl.start = acc && i_in.last_pair;

    spd_lane #(.MAX_PAIRS(MAX_PAIRS), .VALUE_BITS(VALUE_BITS)) u_lane_l (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_wr_en(wr_en), .i_wr_addr(r_cnt[AW-1:0]),
        .i_wr_data(i_in.left_value), .i_ctrl(lane_ctrl), .i_n(cnt_new),
        .i_rd_addr(addr_l), .o_rd_data(data_l), .o_stat(stat_l)
    );

    spd_lane #(.MAX_PAIRS(MAX_PAIRS), .VALUE_BITS(VALUE_BITS)) u_lane_r (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_wr_en(wr_en), .i_wr_addr(r_cnt[AW-1:0]),
        .i_wr_data(i_in.right_value), .i_ctrl(lane_ctrl), .i_n(cnt_new),
        .i_rd_addr(addr_r), .o_rd_data(data_r), .o_stat(stat_r)
    );

    spd_merge #(.MAX_PAIRS(MAX_PAIRS), .VALUE_BITS(VALUE_BITS)) u_merge (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(r_state == T_SORT && !stat_l.busy && !stat_r.busy), .i_n(r_n),
        .o_addr_l(addr_l), .o_addr_r(addr_r), .i_data_l(data_l), .i_data_r(data_r),
        .o_dist(m_dist), .o_sim(m_sim), .o_stat(mstat)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            T_LOAD:  if (lane_ctrl.start) n_state = T_SORT;
            T_SORT:  if (!stat_l.busy && !stat_r.busy) n_state = T_MERGE;
            T_MERGE: if (mstat.done) n_state = T_PUSH;
            T_PUSH:  if (push) n_state = T_LOAD;
            default: n_state = T_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= T_LOAD;
            r_cnt    <= '0;
            r_drop   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (acc) begin
                if (i_in.last_pair) begin
                    r_cnt  <= '0;
                    r_drop <= 1'b0;
                end else begin
                    r_cnt  <= cnt_new;
                    r_drop <= r_drop || !has_room;
                end
            end
            if (push) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (lane_ctrl.start) begin
            r_n        <= cnt_new;
            r_drop_out <= r_drop || !has_room;
        end
        if (push) begin
            r_odist <= m_dist;
            r_osim  <= m_sim;
            r_oused <= USED_W'(r_n);
            r_oexc  <= r_drop_out;
        end
    end

    assign o_out.valid             = r_ovalid;
    assign o_out.distance_total    = r_odist;
    assign o_out.similarity_total  = r_osim;
    assign o_out.pairs_used        = r_oused;
    assign o_out.capacity_exceeded = r_oexc;

    `SPD_ASSERT_NOW(a_ready_only_load, i_clk, i_rst_n, r_state != T_LOAD, !i_in.ready)
    `SPD_ASSERT_NEXT(a_last_starts_sort, i_clk, i_rst_n, lane_ctrl.start, r_state == T_SORT)
    `SPD_ASSERT_NOW(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(MAX_PAIRS))
    `SPD_ASSERT_NOW(a_merge_done_state, i_clk, i_rst_n, mstat.done, r_state == T_MERGE)
endmodule

>>> src/spd_lane.sv
`timescale 1ns / 1ps
module spd_lane import spd_pkg::*; #(
    parameter int MAX_PAIRS  = MAX_PAIRS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    localparam int AW = $clog2(MAX_PAIRS),
    localparam int CW = $clog2(MAX_PAIRS + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic [AW-1:0]         i_wr_addr,
    input  logic [VALUE_BITS-1:0] i_wr_data,
    input  t_lane_ctrl            i_ctrl,
    input  logic [CW-1:0]         i_n,
    input  logic [AW-1:0]         i_rd_addr,
    output logic [VALUE_BITS-1:0] o_rd_data,
    output t_lane_stat            o_stat
);
    logic [VALUE_BITS-1:0] r_mem [MAX_PAIRS];
    logic [VALUE_BITS-1:0] r_rdata;
    t_lane_state           r_state, n_state;
    logic [CW-1:0]         r_n, n_n, r_pass, n_pass, r_j, n_j;
    logic [VALUE_BITS-1:0] r_cur, n_cur;
    logic                  we;
    logic [AW-1:0]         waddr, raddr;
    logic [VALUE_BITS-1:0] wdata;
    logic [CW-1:0]         j_next;

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rdata <= r_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_n    <= n_n;
        r_pass <= n_pass;
        r_j    <= n_j;
        r_cur  <= n_cur;
    end

    assign j_next = CW'(r_j + 1'b1);

    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_pass  = r_pass;
        n_j     = r_j;
        n_cur   = r_cur;
        we      = 1'b0;
        waddr   = i_wr_addr;
        wdata   = i_wr_data;
        raddr   = i_rd_addr;
        unique case (r_state)
            L_IDLE: begin
                we = i_wr_en;
                if (i_ctrl.start && i_n > CW'(1)) begin
                    n_n     = i_n;
                    n_pass  = '0;
                    n_state = L_PRIME;
                end
            end
            L_PRIME: begin
                raddr   = '0;
                n_state = L_FIRST;
            end
            L_FIRST: begin
                raddr   = AW'(1);
                n_cur   = r_rdata;
                n_j     = '0;
                n_state = L_RUN;
            end
            L_RUN: begin
                we    = 1'b1;
                waddr = r_j[AW-1:0];
                raddr = AW'(r_j + CW'(2));
                if (r_rdata < r_cur) begin
                    wdata = r_rdata;
                end else begin
                    wdata = r_cur;
                    n_cur = r_rdata;
                end
                n_j = j_next;
                if (r_j == CW'(r_n - CW'(2))) begin
                    n_state = L_TAIL;
                end
            end
            L_TAIL: begin
                we     = 1'b1;
                waddr  = AW'(r_n - 1'b1);
                wdata  = r_cur;
                n_pass = CW'(r_pass + 1'b1);
                n_state = (CW'(r_pass + 1'b1) == CW'(r_n - 1'b1)) ? L_IDLE : L_PRIME;
            end
            default: n_state = L_IDLE;
        endcase
    end

    assign o_rd_data   = r_rdata;
    assign o_stat.busy = (r_state != L_IDLE);
endmodule

>>> src/spd_merge.sv
`timescale 1ns / 1ps
module spd_merge import spd_pkg::*; #(
    parameter int MAX_PAIRS  = MAX_PAIRS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    localparam int AW = $clog2(MAX_PAIRS),
    localparam int CW = $clog2(MAX_PAIRS + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [CW-1:0]         i_n,
    output logic [AW-1:0]         o_addr_l,
    output logic [AW-1:0]         o_addr_r,
    input  logic [VALUE_BITS-1:0] i_data_l,
    input  logic [VALUE_BITS-1:0] i_data_r,
    output logic [DIST_W-1:0]     o_dist,
    output logic [SIM_W-1:0]      o_sim,
    output t_merge_stat           o_stat
);
    t_merge_state          r_state, n_state;
    logic [CW-1:0]         r_n, n_n, r_i, n_i, r_j, n_j, r_cl, n_cl, r_cr, n_cr;
    logic [VALUE_BITS-1:0] r_v, n_v, diff;
    logic [DIST_W-1:0]     r_dist, n_dist;
    logic [SIM_W-1:0]      r_sim, n_sim, r_p, n_p;
    logic [VALUE_BITS+CW-1:0] prod1;
    logic [SIM_W+CW-1:0]      prod2;
    logic [CW-1:0]         i_inc, j_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_n    <= n_n;
        r_i    <= n_i;
        r_j    <= n_j;
        r_cl   <= n_cl;
        r_cr   <= n_cr;
        r_v    <= n_v;
        r_dist <= n_dist;
        r_sim  <= n_sim;
        r_p    <= n_p;
    end

    assign i_inc = CW'(r_i + 1'b1);
    assign j_inc = CW'(r_j + 1'b1);
    assign diff  = (i_data_l > i_data_r) ? VALUE_BITS'(i_data_l - i_data_r)
                                         : VALUE_BITS'(i_data_r - i_data_l);
    assign prod1 = r_v * r_cl;
    assign prod2 = r_p * r_cr;

    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_i     = r_i;
        n_j     = r_j;
        n_cl    = r_cl;
        n_cr    = r_cr;
        n_v     = r_v;
        n_dist  = r_dist;
        n_sim   = r_sim;
        n_p     = r_p;
        unique case (r_state)
            M_IDLE: begin
                if (i_start) begin
                    n_n     = i_n;
                    n_i     = '0;
                    n_j     = '0;
                    n_dist  = '0;
                    n_sim   = '0;
                    n_state = (i_n == '0) ? M_DONE : M_DRD;
                end
            end
            M_DRD: n_state = M_DACC;
            M_DACC: begin
                n_dist = DIST_W'(r_dist + DIST_W'(diff));
                if (i_inc == r_n) begin
                    n_i     = '0;
                    n_j     = '0;
                    n_state = M_SRD;
                end else begin
                    n_i     = i_inc;
                    n_j     = j_inc;
                    n_state = M_DRD;
                end
            end
            M_SRD: n_state = M_SCMP;
            M_SCMP: begin
                if (i_data_l < i_data_r) begin
                    n_i     = i_inc;
                    n_state = (i_inc < r_n) ? M_SRD : M_DONE;
                end else if (i_data_l > i_data_r) begin
                    n_j     = j_inc;
                    n_state = (j_inc < r_n) ? M_SRD : M_DONE;
                end else begin
                    n_v     = i_data_l;
                    n_cl    = CW'(1);
                    n_cr    = '0;
                    n_i     = i_inc;
                    n_state = (i_inc < r_n) ? M_LRD : M_RRD;
                end
            end
            M_LRD: n_state = M_LCNT;
            M_LCNT: begin
                if (i_data_l == r_v) begin
                    n_cl    = CW'(r_cl + 1'b1);
                    n_i     = i_inc;
                    n_state = (i_inc < r_n) ? M_LRD : M_RRD;
                end else begin
                    n_state = M_RRD;
                end
            end
            M_RRD: n_state = M_RCNT;
            M_RCNT: begin
                if (i_data_r == r_v) begin
                    n_cr    = CW'(r_cr + 1'b1);
                    n_j     = j_inc;
                    n_state = (j_inc < r_n) ? M_RRD : M_MUL1;
                end else begin
                    n_state = M_MUL1;
                end
            end
            M_MUL1: begin
                n_p     = SIM_W'(prod1);
                n_state = M_MUL2;
            end
            M_MUL2: begin
                n_sim   = SIM_W'(r_sim + SIM_W'(prod2));
                n_state = (r_i < r_n && r_j < r_n) ? M_SRD : M_DONE;
            end
            M_DONE: n_state = M_IDLE;
            default: n_state = M_IDLE;
        endcase
    end

    assign o_addr_l    = r_i[AW-1:0];
    assign o_addr_r    = r_j[AW-1:0];
    assign o_dist      = r_dist;
    assign o_sim       = r_sim;
    assign o_stat.busy = (r_state != M_IDLE);
    assign o_stat.done = (r_state == M_DONE);
endmodule
